// ===== hdl/vmalu_pkg.sv =====
package vmalu_pkg;

    // Request codes
    localparam logic [3:0] OP_ZERO  = 4'd0;
    localparam logic [3:0] OP_STORE = 4'd1;
    localparam logic [3:0] OP_ADD   = 4'd2;
    localparam logic [3:0] OP_SUB   = 4'd3;
    localparam logic [3:0] OP_MUL   = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_LT    = 4'd6;
    localparam logic [3:0] OP_LE    = 4'd7;
    localparam logic [3:0] OP_GT    = 4'd8;
    localparam logic [3:0] OP_GE    = 4'd9;
    localparam logic [3:0] OP_EQ    = 4'd10;
    localparam logic [3:0] OP_INC   = 4'd11;
    localparam logic [3:0] OP_DEC   = 4'd12;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DIVZ  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Stream widths
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 7;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    // Which operand number drives the register file read address
    typedef enum logic [1:0] {
        SEL_A,
        SEL_B,
        SEL_R
    } rd_sel_t;

    // Where the read data is captured
    typedef enum logic [2:0] {
        CAP_NUM_A,
        CAP_NUM_B,
        CAP_NUM_R,
        CAP_VAL_A,
        CAP_VAL_B
    } cap_dst_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       cap_en;
        cap_dst_t   cap_dst;
        logic       exec;
        logic       div_start;
        logic       div_cap;
        logic       out_load;
        logic [1:0] out_status;
        logic       out_wrote;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [3:0] op;
        logic       a_ind;
        logic       b_ind;
        logic       r_ind;
        logic       a_ok;
        logic       b_ok;
        logic       r_ok;
        logic       vb_zero;
        logic       div_done;
        logic       out_busy;
    } dp_stat_t;

endpackage

// ===== hdl/vmalu_div.sv =====
module vmalu_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    // One quotient bit per cycle, restoring, on magnitudes
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg, q_reg[31]};
        rem_sub   = rem_sh - {1'b0, dvs_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            neg_next  = dividend[31] ^ divisor[31];
            q_next    = dividend[31] ? (32'd0 - dividend) : dividend;
            dvs_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            rem_next  = 32'd0;
        end else if (busy_reg) begin
            if (!rem_sub[32]) begin
                rem_next = rem_sub[31:0];
                q_next   = {q_reg[30:0], 1'b1};
            end else begin
                rem_next = rem_sh[31:0];
                q_next   = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - q_reg) : q_reg;

endmodule

// ===== hdl/vmalu_dp.sv =====
module vmalu_dp #(
    parameter int REG_COUNT = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  vmalu_pkg::dp_cmd_t               cmd,
    output vmalu_pkg::dp_stat_t              stat,
    input  logic [vmalu_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [vmalu_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [vmalu_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [vmalu_pkg::M_TUSER_W-1:0]  m_tuser
);

    localparam int          IW        = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam logic [31:0] REG_LIMIT = 32'(REG_COUNT);

    // Instruction word
    logic [3:0]  op_reg;
    logic        a_ind_reg, b_ind_reg, r_ind_reg;
    logic [31:0] num_a_reg, num_b_reg, num_r_reg;
    logic [31:0] va_reg, vb_reg;
    logic [31:0] res_reg, res_next;

    // Register file with per-entry valid bits for the cleared state
    logic [31:0]          rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [31:0]          rd_q_reg;
    logic                 rd_valid_reg;
    logic [IW-1:0]        rd_addr;
    logic [IW-1:0]        wr_addr;
    logic [31:0]          rd_val;
    logic                 wr_en;

    // Output word
    logic                        m_tvalid_reg;
    logic [vmalu_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [vmalu_pkg::M_TUSER_W-1:0] m_tuser_reg;

    logic        div_done;
    logic [31:0] div_q;

    vmalu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (va_reg),
        .divisor  (vb_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Read address select
    always_comb begin
        case (cmd.rd_sel)
            vmalu_pkg::SEL_A: rd_addr = num_a_reg[IW-1:0];
            vmalu_pkg::SEL_B: rd_addr = num_b_reg[IW-1:0];
            vmalu_pkg::SEL_R: rd_addr = num_r_reg[IW-1:0];
            default:          rd_addr = num_r_reg[IW-1:0];
        endcase
    end

    assign rd_val  = rd_valid_reg ? rd_q_reg : 32'd0;
    assign wr_addr = num_r_reg[IW-1:0];
    assign wr_en   = cmd.out_load && cmd.out_wrote;

    // Memory array: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rf_mem[wr_addr] <= res_reg;
        end
        if (cmd.rd_en) begin
            rd_q_reg <= rf_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid_reg <= '0;
        end else if (wr_en) begin
            rf_valid_reg[wr_addr] <= 1'b1;
        end
        if (cmd.rd_en) begin
            rd_valid_reg <= rf_valid_reg[rd_addr];
        end
    end

    // ALU
    always_comb begin
        case (op_reg)
            vmalu_pkg::OP_ZERO:  res_next = 32'd0;
            vmalu_pkg::OP_STORE: res_next = va_reg;
            vmalu_pkg::OP_ADD:   res_next = va_reg + vb_reg;
            vmalu_pkg::OP_SUB:   res_next = va_reg - vb_reg;
            vmalu_pkg::OP_MUL:   res_next = va_reg * vb_reg;
            vmalu_pkg::OP_LT:    res_next = {31'd0, $signed(va_reg) < $signed(vb_reg)};
            vmalu_pkg::OP_LE:    res_next = {31'd0, !($signed(vb_reg) < $signed(va_reg))};
            vmalu_pkg::OP_GT:    res_next = {31'd0, $signed(vb_reg) < $signed(va_reg)};
            vmalu_pkg::OP_GE:    res_next = {31'd0, !($signed(va_reg) < $signed(vb_reg))};
            vmalu_pkg::OP_EQ:    res_next = {31'd0, va_reg == vb_reg};
            vmalu_pkg::OP_INC:   res_next = va_reg + 32'd1;
            vmalu_pkg::OP_DEC:   res_next = va_reg - 32'd1;
            default:             res_next = 32'd0;
        endcase
    end

    // Operand and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_tuser[3:0];
            a_ind_reg <= s_tuser[4];
            b_ind_reg <= s_tuser[5];
            r_ind_reg <= s_tuser[6];
            num_a_reg <= s_tdata[31:0];
            num_b_reg <= s_tdata[63:32];
            num_r_reg <= s_tdata[95:64];
            va_reg    <= s_tdata[31:0];
        end
        if (cmd.cap_en) begin
            case (cmd.cap_dst)
                vmalu_pkg::CAP_NUM_A: num_a_reg <= rd_val;
                vmalu_pkg::CAP_NUM_B: num_b_reg <= rd_val;
                vmalu_pkg::CAP_NUM_R: num_r_reg <= rd_val;
                vmalu_pkg::CAP_VAL_A: va_reg    <= rd_val;
                vmalu_pkg::CAP_VAL_B: vb_reg    <= rd_val;
                default:              vb_reg    <= rd_val;
            endcase
        end
        if (cmd.exec) begin
            res_reg <= res_next;
        end else if (cmd.div_cap) begin
            res_reg <= div_q;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_tuser_reg <= {cmd.out_wrote, cmd.out_status};
            if (cmd.out_wrote) begin
                m_tdata_reg <= {3'd0, res_reg, num_r_reg[4:0]};
            end else begin
                m_tdata_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Status to the controller
    always_comb begin
        stat.op       = op_reg;
        stat.a_ind    = a_ind_reg;
        stat.b_ind    = b_ind_reg;
        stat.r_ind    = r_ind_reg;
        stat.a_ok     = num_a_reg < REG_LIMIT;
        stat.b_ok     = num_b_reg < REG_LIMIT;
        stat.r_ok     = num_r_reg < REG_LIMIT;
        stat.vb_zero  = vb_reg == 32'd0;
        stat.div_done = div_done;
        stat.out_busy = m_tvalid_reg && !m_tready;
    end

endmodule

// ===== hdl/vmalu_ctrl.sv =====
module vmalu_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  vmalu_pkg::dp_stat_t stat,
    output vmalu_pkg::dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_STORE_RD,
        S_STORE_CAP,
        S_RES_A,
        S_CAP_A,
        S_RES_B,
        S_CAP_B,
        S_RES_R,
        S_CAP_R,
        S_CHK,
        S_RD_A,
        S_RD_B,
        S_CAP_VB,
        S_RD_D,
        S_CAP_VD,
        S_EXEC,
        S_DIV,
        S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] fin_status_reg, fin_status_next;
    logic       fin_wrote_reg, fin_wrote_next;
    logic       is_bin;
    logic       is_incdec;

    assign is_bin    = (stat.op >= vmalu_pkg::OP_ADD) && (stat.op <= vmalu_pkg::OP_EQ);
    assign is_incdec = (stat.op == vmalu_pkg::OP_INC) || (stat.op == vmalu_pkg::OP_DEC);
    assign s_tready  = (state_reg == S_IDLE);

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        fin_status_next = fin_status_reg;
        fin_wrote_next  = fin_wrote_reg;
        cmd             = '0;
        cmd.rd_sel      = vmalu_pkg::SEL_A;
        cmd.cap_dst     = vmalu_pkg::CAP_VAL_A;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                fin_status_next = vmalu_pkg::ST_OK;
                fin_wrote_next  = 1'b0;
                case (stat.op)
                    vmalu_pkg::OP_ZERO, vmalu_pkg::OP_INC, vmalu_pkg::OP_DEC:
                        state_next = S_RES_R;
                    vmalu_pkg::OP_STORE:
                        state_next = stat.a_ind ? S_STORE_RD : S_RES_R;
                    vmalu_pkg::OP_ADD, vmalu_pkg::OP_SUB, vmalu_pkg::OP_MUL,
                    vmalu_pkg::OP_DIV, vmalu_pkg::OP_LT, vmalu_pkg::OP_LE,
                    vmalu_pkg::OP_GT, vmalu_pkg::OP_GE, vmalu_pkg::OP_EQ:
                        state_next = S_RES_A;
                    default:
                        state_next = S_FINISH;
                endcase
            end
            // Store from a register: value read, not an index
            S_STORE_RD: begin
                if (stat.a_ok) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = vmalu_pkg::SEL_A;
                    state_next = S_STORE_CAP;
                end else begin
                    fin_status_next = vmalu_pkg::ST_RANGE;
                    state_next      = S_FINISH;
                end
            end
            S_STORE_CAP: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_dst = vmalu_pkg::CAP_VAL_A;
                state_next  = S_RES_R;
            end
            // Indirect resolution of a, b, then destination
            S_RES_A: begin
                if (!stat.a_ind) begin
                    state_next = S_RES_B;
                end else if (stat.a_ok) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = vmalu_pkg::SEL_A;
                    state_next = S_CAP_A;
                end else begin
                    fin_status_next = vmalu_pkg::ST_RANGE;
                    state_next      = S_FINISH;
                end
            end
            S_CAP_A: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_dst = vmalu_pkg::CAP_NUM_A;
                state_next  = S_RES_B;
            end
            S_RES_B: begin
                if (!stat.b_ind) begin
                    state_next = S_RES_R;
                end else if (stat.b_ok) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = vmalu_pkg::SEL_B;
                    state_next = S_CAP_B;
                end else begin
                    fin_status_next = vmalu_pkg::ST_RANGE;
                    state_next      = S_FINISH;
                end
            end
            S_CAP_B: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_dst = vmalu_pkg::CAP_NUM_B;
                state_next  = S_RES_R;
            end
            S_RES_R: begin
                if (!stat.r_ind) begin
                    state_next = S_CHK;
                end else if (stat.r_ok) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = vmalu_pkg::SEL_R;
                    state_next = S_CAP_R;
                end else begin
                    fin_status_next = vmalu_pkg::ST_RANGE;
                    state_next      = S_FINISH;
                end
            end
            S_CAP_R: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_dst = vmalu_pkg::CAP_NUM_R;
                state_next  = S_CHK;
            end
            // Range check of the resolved register numbers
            S_CHK: begin
                if (!stat.r_ok || (is_bin && !(stat.a_ok && stat.b_ok))) begin
                    fin_status_next = vmalu_pkg::ST_RANGE;
                    state_next      = S_FINISH;
                end else if (is_bin) begin
                    state_next = S_RD_A;
                end else if (is_incdec) begin
                    state_next = S_RD_D;
                end else begin
                    state_next = S_EXEC;
                end
            end
            // Operand reads, overlapped with capture
            S_RD_A: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = vmalu_pkg::SEL_A;
                state_next = S_RD_B;
            end
            S_RD_B: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_dst = vmalu_pkg::CAP_VAL_A;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = vmalu_pkg::SEL_B;
                state_next  = S_CAP_VB;
            end
            S_CAP_VB: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_dst = vmalu_pkg::CAP_VAL_B;
                state_next  = S_EXEC;
            end
            S_RD_D: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = vmalu_pkg::SEL_R;
                state_next = S_CAP_VD;
            end
            S_CAP_VD: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_dst = vmalu_pkg::CAP_VAL_A;
                state_next  = S_EXEC;
            end
            S_EXEC: begin
                if (stat.op == vmalu_pkg::OP_DIV) begin
                    if (stat.vb_zero) begin
                        fin_status_next = vmalu_pkg::ST_DIVZ;
                        state_next      = S_FINISH;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end else begin
                    cmd.exec       = 1'b1;
                    fin_wrote_next = 1'b1;
                    state_next     = S_FINISH;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.div_cap    = 1'b1;
                    fin_wrote_next = 1'b1;
                    state_next     = S_FINISH;
                end
            end
            // Write back and hand the result word to the output register
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = fin_status_reg;
                    cmd.out_wrote  = fin_wrote_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            fin_status_reg <= vmalu_pkg::ST_OK;
            fin_wrote_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fin_status_reg <= fin_status_next;
            fin_wrote_reg  <= fin_wrote_next;
        end
    end

endmodule

// ===== hdl/vm_integer_register_alu.sv =====
// Integer register ALU of a register virtual machine.
//
// Input stream (s_): one decoded instruction per word. The block reads its
// operands from an internal file of REG_COUNT 32-bit registers, optionally
// through one indirect read per operand, and writes one destination register.
// Output stream (m_): one result word per instruction, carrying status,
// the write flag, the destination index and the value written.
//
// Sequencing: one instruction at a time on a single read port of the register
// file. A binary op resolves its indirect operands, reads both values and
// executes; a divide runs the one-bit-per-cycle divider before finishing.
// s_tready is high only between instructions.
// Reset: all registers read as zero after reset (per-entry valid bits), the
// output register is empty and the block is ready at once.
// Stall: a finished word waits in the output register while m_tready is low;
// the next instruction is accepted and worked on meanwhile, and its result
// waits until the output register is free.
module vm_integer_register_alu #(
    parameter int REG_COUNT = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // a_number[31:0], b_number[63:32], r_number[95:64]
    input  logic [95:0] s_tdata,
    // req_type[3:0], a_indirect[4], b_indirect[5], r_indirect[6]
    input  logic [6:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // dest_index[4:0], dest_value[36:5], zero pad [39:37]
    output logic [39:0] m_tdata,
    // status[1:0], wrote[2]
    output logic [2:0]  m_tuser
);

    vmalu_pkg::dp_cmd_t  cmd;
    vmalu_pkg::dp_stat_t stat;

    vmalu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vmalu_dp #(
        .REG_COUNT (REG_COUNT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // One instruction in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("instruction accepted while another is in flight");

    // A result word is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !stat.out_busy)
        else $error("output word overwritten");

    // A write only comes with ok status
    a_write_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == vmalu_pkg::ST_OK)
        else $error("write reported with error status");

    // Without a write, index and value are zero
    a_nowrite_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[2] |-> m_tdata == 40'd0)
        else $error("nonzero destination fields without a write");

endmodule

// ===== verif/vmalu_checker.sv =====
module vmalu_checker #(
    parameter int REG_COUNT = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [vmalu_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [vmalu_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [vmalu_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [vmalu_pkg::M_TUSER_W-1:0] m_tuser,
    output int                              fail_count,
    output int                              pend_count
);

    localparam int IW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    typedef struct packed {
        logic [1:0]  status;
        logic        wrote;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
    } alu_result_t;

    // Shadow register file and the results still owed by the block
    logic [31:0] vm_regs [REG_COUNT];
    alu_result_t owed_results [$];
    int          mismatches = 0;

    assign fail_count = mismatches;
    assign pend_count = owed_results.size();

    // Follow one indirection if asked; returns 0 when any number is out of range
    function automatic logic resolve_reg(input logic [31:0] num, input logic ind,
                                         output logic [31:0] idx);
        idx = num;
        if (ind) begin
            if (num >= REG_COUNT)
                return 1'b0;
            idx = vm_regs[num[IW-1:0]];
        end
        return idx < REG_COUNT;
    endfunction

    // Signed divide, truncating toward zero; min / -1 wraps
    function automatic logic [31:0] div_toward_zero(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] mx, my, q;
        mx = x[31] ? -x : x;
        my = y[31] ? -y : y;
        q  = mx / my;
        return (x[31] != y[31]) ? -q : q;
    endfunction

    // Execute one instruction on the shadow file and return its result word
    function automatic alu_result_t run_instruction(
        input logic [vmalu_pkg::S_TUSER_W-1:0] user,
        input logic [vmalu_pkg::S_TDATA_W-1:0] data);
        logic [3:0]  op;
        logic [31:0] an, bn, rn, ia, ib, id, va, vb, val;
        logic        ok_a, ok_b, ok_r, wr;
        logic [1:0]  st;
        alu_result_t res;
        op  = user[3:0];
        an  = data[31:0];
        bn  = data[63:32];
        rn  = data[95:64];
        st  = vmalu_pkg::ST_OK;
        wr  = 1'b0;
        val = '0;
        id  = '0;
        ia  = '0;
        ib  = '0;
        case (op)
            vmalu_pkg::OP_ZERO, vmalu_pkg::OP_STORE, vmalu_pkg::OP_INC,
            vmalu_pkg::OP_DEC: begin
                va = an;
                if (op == vmalu_pkg::OP_STORE && user[4]) begin
                    if (an >= REG_COUNT)
                        st = vmalu_pkg::ST_RANGE;
                    else
                        va = vm_regs[an[IW-1:0]];
                end
                if (st == vmalu_pkg::ST_OK && !resolve_reg(rn, user[6], id))
                    st = vmalu_pkg::ST_RANGE;
                if (st == vmalu_pkg::ST_OK) begin
                    wr = 1'b1;
                    case (op)
                        vmalu_pkg::OP_ZERO:  val = '0;
                        vmalu_pkg::OP_STORE: val = va;
                        vmalu_pkg::OP_INC:   val = vm_regs[id[IW-1:0]] + 32'd1;
                        default:             val = vm_regs[id[IW-1:0]] - 32'd1;
                    endcase
                end
            end
            vmalu_pkg::OP_ADD, vmalu_pkg::OP_SUB, vmalu_pkg::OP_MUL, vmalu_pkg::OP_DIV,
            vmalu_pkg::OP_LT, vmalu_pkg::OP_LE, vmalu_pkg::OP_GT, vmalu_pkg::OP_GE,
            vmalu_pkg::OP_EQ: begin
                // all indirections read before the write
                ok_a = resolve_reg(an, user[4], ia);
                ok_b = resolve_reg(bn, user[5], ib);
                ok_r = resolve_reg(rn, user[6], id);
                if (!(ok_a && ok_b && ok_r)) begin
                    st = vmalu_pkg::ST_RANGE;
                end else begin
                    va = vm_regs[ia[IW-1:0]];
                    vb = vm_regs[ib[IW-1:0]];
                    wr = 1'b1;
                    case (op)
                        vmalu_pkg::OP_ADD: val = va + vb;
                        vmalu_pkg::OP_SUB: val = va - vb;
                        vmalu_pkg::OP_MUL: val = va * vb;
                        vmalu_pkg::OP_DIV: begin
                            if (vb == '0) begin
                                st = vmalu_pkg::ST_DIVZ;
                                wr = 1'b0;
                            end else begin
                                val = div_toward_zero(va, vb);
                            end
                        end
                        vmalu_pkg::OP_LT:  val = {31'd0, $signed(va) <  $signed(vb)};
                        vmalu_pkg::OP_LE:  val = {31'd0, $signed(va) <= $signed(vb)};
                        vmalu_pkg::OP_GT:  val = {31'd0, $signed(va) >  $signed(vb)};
                        vmalu_pkg::OP_GE:  val = {31'd0, $signed(va) >= $signed(vb)};
                        default:           val = {31'd0, va == vb};
                    endcase
                end
            end
            default: ; // unused codes: no-op, status ok
        endcase
        if (wr) begin
            vm_regs[id[IW-1:0]] = val;
        end else begin
            id  = '0;
            val = '0;
        end
        res.status     = st;
        res.wrote      = wr;
        res.dest_index = id[4:0];
        res.dest_value = val;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Sample both channels at the rising edge
    always @(posedge aclk) begin : watch
        alu_result_t got, want;
        if (!aresetn) begin
            foreach (vm_regs[i])
                vm_regs[i] = '0;
            owed_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.status     = m_tuser[1:0];
                got.wrote      = m_tuser[2];
                got.dest_index = m_tdata[4:0];
                got.dest_value = m_tdata[36:5];
                if (owed_results.size() == 0) begin
                    $error("result word with nothing outstanding: %0h", got);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("wrote", 32'(want.wrote), 32'(got.wrote));
                    check_field("dest_index", 32'(want.dest_index), 32'(got.dest_index));
                    check_field("dest_value", want.dest_value, got.dest_value);
                    check_field("pad", 32'd0, 32'(m_tdata[39:37]));
                end
            end
            if (s_tvalid && s_tready)
                owed_results.push_back(run_instruction(s_tuser, s_tdata));
        end
    end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

    localparam int REGS = 32;

    // Request codes the block treats as no operation
    localparam logic [3:0] OP_SPARE_LO = 4'd13;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [vmalu_pkg::S_TDATA_W-1:0] s_tdata;
    logic [vmalu_pkg::S_TUSER_W-1:0] s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [vmalu_pkg::M_TDATA_W-1:0] m_tdata;
    logic [vmalu_pkg::M_TUSER_W-1:0] m_tuser;
    int                              fail_count;
    int                              pend_count;
    logic                            no_idle = 1'b0;

    always #6 aclk = ~aclk;

    vm_integer_register_alu #(
        .REG_COUNT(REGS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    vmalu_checker #(
        .REG_COUNT(REGS)
    ) i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .fail_count(fail_count),
        .pend_count(pend_count)
    );

    // Result side back-pressure
    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 28);
    end

    // Present one instruction word; called and returns at a falling edge
    task automatic send_instr(input logic [3:0] op, input logic ai, input logic [31:0] an,
                              input logic bi, input logic [31:0] bn,
                              input logic ri, input logic [31:0] rn);
        while (!no_idle && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {rn, bn, an};
        s_tuser  <= {ri, bi, ai, op};
        s_tvalid <= 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
    endtask

    // Register number: mostly valid, sometimes out of range
    function automatic logic [31:0] pick_reg();
        case ($urandom_range(0, 19))
            0:       return $urandom();
            1:       return REGS + $urandom_range(0, 3);
            2:       return -$urandom_range(1, 4);
            default: return $urandom_range(0, REGS - 1);
        endcase
    endfunction

    // Data value for stores: pointers, extremes and full random
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom_range(0, REGS - 1);
            3: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'hffff_ffff;
                    3:       return 32'd1;
                    default: return 32'd0;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic logic coin30();
        return $urandom_range(0, 99) < 30;
    endfunction

    initial begin
        logic [3:0] op;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        aresetn  = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extremes, every operation, range and divide corners
        send_instr(vmalu_pkg::OP_STORE, 1'b0, 32'h8000_0000, 1'b0, 0, 1'b0, 1);
        send_instr(vmalu_pkg::OP_STORE, 1'b0, 32'hffff_ffff, 1'b0, 0, 1'b0, 2);
        send_instr(vmalu_pkg::OP_STORE, 1'b0, 32'h7fff_ffff, 1'b0, 0, 1'b0, 3);
        send_instr(vmalu_pkg::OP_STORE, 1'b0, 4, 1'b0, 0, 1'b0, 4);
        send_instr(vmalu_pkg::OP_STORE, 1'b0, 3, 1'b0, 0, 1'b0, 31);
        send_instr(vmalu_pkg::OP_DIV, 1'b0, 1, 1'b0, 2, 1'b0, 5);    // most negative / -1
        send_instr(vmalu_pkg::OP_ADD, 1'b0, 3, 1'b0, 3, 1'b0, 6);    // overflow wraps
        send_instr(vmalu_pkg::OP_SUB, 1'b0, 1, 1'b0, 3, 1'b0, 7);
        send_instr(vmalu_pkg::OP_MUL, 1'b0, 3, 1'b1, 4, 1'b0, 8);    // b through r4
        send_instr(vmalu_pkg::OP_STORE, 1'b0, -7, 1'b0, 0, 1'b0, 10);
        send_instr(vmalu_pkg::OP_STORE, 1'b0, 2, 1'b0, 0, 1'b0, 11);
        send_instr(vmalu_pkg::OP_DIV, 1'b0, 10, 1'b0, 11, 1'b0, 12); // -7 / 2 is -3
        send_instr(vmalu_pkg::OP_DIV, 1'b0, 2, 1'b0, 0, 1'b0, 9);    // divide by zero
        send_instr(vmalu_pkg::OP_LT, 1'b0, 1, 1'b0, 3, 1'b0, 13);
        send_instr(vmalu_pkg::OP_LE, 1'b0, 3, 1'b0, 3, 1'b0, 14);
        send_instr(vmalu_pkg::OP_GT, 1'b0, 1, 1'b0, 3, 1'b0, 15);
        send_instr(vmalu_pkg::OP_GE, 1'b1, 31, 1'b0, 3, 1'b0, 16);   // a through r31
        send_instr(vmalu_pkg::OP_INC, 1'b0, 0, 1'b0, 0, 1'b0, 3);    // max + 1 wraps
        send_instr(vmalu_pkg::OP_DEC, 1'b0, 0, 1'b0, 0, 1'b0, 1);    // min - 1 wraps
        send_instr(vmalu_pkg::OP_EQ, 1'b0, 2, 1'b0, 2, 1'b1, 31);    // dest through r31
        send_instr(vmalu_pkg::OP_ZERO, 1'b0, 0, 1'b0, 0, 1'b1, 1);   // r1 out of range
        send_instr(vmalu_pkg::OP_STORE, 1'b1, 31, 1'b0, 0, 1'b0, 17); // store from a reg
        send_instr(vmalu_pkg::OP_ADD, 1'b0, REGS, 1'b0, 0, 1'b0, 18); // direct out of range
        send_instr(vmalu_pkg::OP_DIV, 1'b0, 0, 1'b0, 0, 1'b0, -1);   // range wins
        send_instr(vmalu_pkg::OP_STORE, 1'b1, 40, 1'b0, 0, 1'b0, 19); // source out of range
        send_instr(OP_SPARE_HI, 1'b1, $urandom(), 1'b1, $urandom(), 1'b1, $urandom());
        send_instr(vmalu_pkg::OP_ZERO, 1'b0, 0, 1'b0, 0, 1'b0, 2);

        // Random: pointer stores keep indirection mostly valid
        for (int n = 0; n < 1125; n++) begin
            no_idle <= (n >= 400 && n < 650);
            if ($urandom_range(0, 99) < 20) begin
                send_instr(vmalu_pkg::OP_STORE, 1'b0, $urandom_range(0, REGS - 1), 1'b0,
                           $urandom(), 1'b0, $urandom_range(0, REGS - 1));
            end else begin
                if ($urandom_range(0, 99) < 3)
                    op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                else
                    op = 4'($urandom_range(vmalu_pkg::OP_ZERO, vmalu_pkg::OP_DEC));
                if (op == vmalu_pkg::OP_STORE && !coin30())
                    send_instr(op, 1'b0, pick_value(), coin30(), $urandom(), coin30(),
                               pick_reg());
                else
                    send_instr(op, coin30(), pick_reg(), coin30(), pick_reg(),
                               coin30(), pick_reg());
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then a margin for any stray word
        while (pend_count != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (fail_count == 0 && pend_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #6_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/vmalu_pkg.sv
hdl/vmalu_div.sv
hdl/vmalu_dp.sv
hdl/vmalu_ctrl.sv
hdl/vm_integer_register_alu.sv
verif/vmalu_checker.sv
verif/tb_top.sv
